@@ rtl/isg_pkg.sv @@
// shared types, constants and the sine table entry function for the imu sine stimulus generator
// no dependencies; used by isg_chan and imu_sine_stimulus_generator_unit
`default_nettype none

package isg_pkg;

    // sensor groups, one phase accumulator each
    localparam int NUM_GRP = 4;
    localparam int NUM_CH  = 10;

    localparam logic [1:0] GRP_ACCEL = 2'd0;
    localparam logic [1:0] GRP_GYRO  = 2'd1;
    localparam logic [1:0] GRP_MAG   = 2'd2;
    localparam logic [1:0] GRP_TEMP  = 2'd3;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ACCEL_STEP,
        REG_GYRO_STEP,
        REG_MAG_STEP,
        REG_TEMP_STEP,
        REG_ACCEL_AMP,
        REG_GYRO_AMP,
        REG_MAG_AMP,
        REG_GRAVITY
    } isg_reg_e;

    // register reset values
    localparam logic [31:0] STEP_RESET [NUM_GRP] = '{
        32'd21474836, 32'd12884902, 32'd8589935, 32'd683565
    };
    localparam logic [14:0]        ACCEL_AMP_RESET = 15'd19613;
    localparam logic [14:0]        GYRO_AMP_RESET  = 15'd16384;
    localparam logic [14:0]        MAG_AMP_RESET   = 15'd5000;
    localparam logic signed [15:0] GRAVITY_RESET   = 16'sd9807;

    // channel to accumulator map and fixed phase offsets (fraction of a cycle times 2^32)
    localparam logic [1:0] CH_GROUP [NUM_CH] = '{
        GRP_ACCEL, GRP_ACCEL, GRP_ACCEL,
        GRP_GYRO,  GRP_GYRO,  GRP_GYRO,
        GRP_MAG,   GRP_MAG,   GRP_MAG,
        GRP_TEMP
    };
    localparam logic [31:0] CH_OFFSET [NUM_CH] = '{
        32'h0000_0000, 32'h2000_0000, 32'h4000_0000,
        32'd0,         32'd715827883, 32'd1431655765,
        32'd0,         32'd357913941, 32'd715827883,
        32'd0
    };

    // temperature channel: 2500 + trunc(100 * sine)
    localparam logic [14:0]        TEMP_SCALE = 15'd100;
    localparam logic signed [15:0] TEMP_BASE  = 16'sd2500;

    // pi/2 in q30
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // stage loads of one output channel
    typedef struct packed {
        logic ld_prod;
        logic ld_quot;
        logic ld_out;
    } isg_ctl_t;

    // t * x^2 in q30, truncated after each product
    function automatic logic [63:0] sq_step(input logic [63:0] t, input logic [63:0] x);
        logic [63:0] p;
        p = (t * x) >> 30;
        return (p * x) >> 30;
    endfunction

    function automatic logic [63:0] sub_floor(input logic [63:0] a, input logic [63:0] b);
        return (a >= b) ? a - b : 64'd0;
    endfunction

    // one quarter-wave entry from its q30 angle, taylor series through x^17
    function automatic logic [31:0] sine_entry(input logic [63:0] x, input logic [63:0] peak);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        term = x;
        sum  = x;
        term = sq_step(term, x) / 64'd6;
        sum  = sub_floor(sum, term);
        term = sq_step(term, x) / 64'd20;
        sum  = sum + term;
        term = sq_step(term, x) / 64'd42;
        sum  = sub_floor(sum, term);
        term = sq_step(term, x) / 64'd72;
        sum  = sum + term;
        term = sq_step(term, x) / 64'd110;
        sum  = sub_floor(sum, term);
        term = sq_step(term, x) / 64'd156;
        sum  = sum + term;
        term = sq_step(term, x) / 64'd210;
        sum  = sub_floor(sum, term);
        term = sq_step(term, x) / 64'd272;
        sum  = sum + term;
        v = (sum * peak + (64'd1 << 29)) >> 30;
        if (v > peak)
        begin
            v = peak;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/isg_ram.sv @@
// generic single-write, dual-read ram with registered read data
// no dependencies
`default_nettype none

module isg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1025
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

@@ rtl/isg_chan.sv @@
// one output channel: scale a signed table sample by an amplitude, divide by the table peak,
// add an offset and saturate to 16 bits; depends on isg_pkg
`default_nettype none

module isg_chan #(
    parameter int EW    = 15,
    parameter bit ROUND = 1'b1
) (
    input  wire logic                clk,
    input  wire isg_pkg::isg_ctl_t   ctl,
    input  wire logic [EW-1:0]       mag,
    input  wire logic                neg,
    input  wire logic [14:0]         amp,
    input  wire logic signed [15:0]  offset,
    output logic      [15:0]         value
);

    localparam logic [EW-1:0] PEAK = {EW{1'b1}};
    localparam int NW = EW + 16;
    localparam int RW = ((EW > 16) ? EW : 16) + 1;
    localparam logic [NW-1:0] HALF = ROUND ? NW'(PEAK >> 1) : '0;

    logic [NW-1:0] prod_reg;
    logic          neg_p_reg;
    logic [15:0]   quot_reg;
    logic          neg_q_reg;

    // stage 1: product plus rounding term
    always_ff @(posedge clk)
    begin
        if (ctl.ld_prod)
        begin
            prod_reg  <= NW'(mag * amp) + HALF;
            neg_p_reg <= neg;
        end
    end

    // stage 2: divide by 2^EW - 1 by folding the high part onto the low part
    logic [RW-1:0] q0, q1, q2, q3;
    logic [RW-1:0] r0, r1, r2, r3;
    logic [17:0]   quot_next;

    always_comb
    begin
        q0 = RW'(prod_reg[NW-1:EW]);
        r0 = RW'(prod_reg[EW-1:0]) + q0;
        q1 = r0 >> EW;
        r1 = RW'(r0[EW-1:0]) + q1;
        q2 = r1 >> EW;
        r2 = RW'(r1[EW-1:0]) + q2;
        q3 = r2 >> EW;
        r3 = RW'(r2[EW-1:0]) + q3;
        quot_next = 18'(q0) + 18'(q1) + 18'(q2) + 18'(q3);
        if (r3 >= RW'(PEAK))
        begin
            quot_next = quot_next + 18'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_quot)
        begin
            quot_reg  <= quot_next[15:0];
            neg_q_reg <= neg_p_reg;
        end
    end

    // stage 3: sign, offset, saturation
    logic signed [17:0] sum;
    logic        [15:0] value_next;

    always_comb
    begin
        if (neg_q_reg)
        begin
            sum = $signed({{2{offset[15]}}, offset}) - $signed({2'b00, quot_reg});
        end
        else
        begin
            sum = $signed({{2{offset[15]}}, offset}) + $signed({2'b00, quot_reg});
        end
        if (sum > 18'sd32767)
        begin
            value_next = 16'h7fff;
        end
        else if (sum < -18'sd32768)
        begin
            value_next = 16'h8000;
        end
        else
        begin
            value_next = sum[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_out)
        begin
            value <= value_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/imu_sine_stimulus_generator_unit.sv @@
// top level of the imu sine stimulus generator: phase accumulators, sine table rams and
// output channels; depends on isg_pkg, isg_ram and isg_chan
`default_nettype none

// synthetic imu sample source built around a quarter-wave sine table
//
// input stream (s_*): one word per requested sample; s_tdata[0] = advance. with advance
// high the four phase accumulators (accel, gyro, mag, temperature) step first, with advance
// low the sample at the current phases is emitted again
// output stream (m_*): one word per input word, 9 saturated 16-bit channels plus a 12-bit
// temperature in hundredths of a degree
// config port: cfg_we writes cfg_data into the register picked by cfg_index; change
// registers only while no sample is in flight
//
// pipeline: an accepted input word passes the accumulator, channel phase, table ram read,
// scale, divide and offset/saturate stages before its sample shows on m_tvalid
// throughput: one word per cycle while the output is not stalled; each table ram serves two channels per cycle
// stall: stages collapse bubbles, so input keeps flowing until every stage is full;
// the output register holds its word until m_tready
// reset: accumulators clear to phase zero, registers take their defaults, then a fill
// sweep writes the SINE_TABLE_DEPTH+1 table entries, one per cycle, before s_tready rises
module imu_sine_stimulus_generator_unit #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SINE_BITS        = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // config write port
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data,
    // input stream
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // advance, zero pad
    // output stream
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, mag_x, mag_y, mag_z,
    // temperature (12 bits), zero pad
    output logic      [159:0]  m_tdata
);

    localparam int NUM_CH  = isg_pkg::NUM_CH;
    localparam int NUM_GRP = isg_pkg::NUM_GRP;
    localparam int NUM_RAM = NUM_CH / 2;
    localparam int EW      = SINE_BITS - 1;                 // table entry width
    localparam int AW      = $clog2(SINE_TABLE_DEPTH + 1);  // table address width
    localparam logic [63:0] PEAK = (64'd1 << EW) - 64'd1;

    // ---------------------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------------------
    logic [31:0]        step_reg [NUM_GRP];
    logic [14:0]        accel_amp_reg;
    logic [14:0]        gyro_amp_reg;
    logic [14:0]        mag_amp_reg;
    logic signed [15:0] gravity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NUM_GRP; g++)
            begin
                step_reg[g] <= isg_pkg::STEP_RESET[g];
            end
            accel_amp_reg <= isg_pkg::ACCEL_AMP_RESET;
            gyro_amp_reg  <= isg_pkg::GYRO_AMP_RESET;
            mag_amp_reg   <= isg_pkg::MAG_AMP_RESET;
            gravity_reg   <= isg_pkg::GRAVITY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                isg_pkg::REG_ACCEL_STEP: step_reg[isg_pkg::GRP_ACCEL] <= cfg_data;
                isg_pkg::REG_GYRO_STEP:  step_reg[isg_pkg::GRP_GYRO]  <= cfg_data;
                isg_pkg::REG_MAG_STEP:   step_reg[isg_pkg::GRP_MAG]   <= cfg_data;
                isg_pkg::REG_TEMP_STEP:  step_reg[isg_pkg::GRP_TEMP]  <= cfg_data;
                isg_pkg::REG_ACCEL_AMP:  accel_amp_reg <= cfg_data[14:0];
                isg_pkg::REG_GYRO_AMP:   gyro_amp_reg  <= cfg_data[14:0];
                isg_pkg::REG_MAG_AMP:    mag_amp_reg   <= cfg_data[14:0];
                isg_pkg::REG_GRAVITY:    gravity_reg   <= $signed(cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // table fill after reset: constant entries copied into every ram, one per cycle
    // ---------------------------------------------------------------------------------
    logic [EW-1:0] sine_rom [SINE_TABLE_DEPTH + 1];

    for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++)
    begin : g_rom
        localparam logic [63:0] X = (isg_pkg::PI_HALF_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
        localparam logic [31:0] E = isg_pkg::sine_entry(X, PEAK);
        assign sine_rom[i] = E[EW-1:0];
    end

    logic [AW-1:0] fill_cnt_reg;
    logic          fill_done_reg;
    logic [EW-1:0] fill_data_reg;
    logic [AW-1:0] fill_addr_reg;
    logic          fill_we_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg  <= '0;
            fill_done_reg <= 1'b0;
        end
        else if (!fill_done_reg)
        begin
            if (fill_cnt_reg == AW'(SINE_TABLE_DEPTH))
            begin
                fill_done_reg <= 1'b1;
            end
            else
            begin
                fill_cnt_reg <= fill_cnt_reg + AW'(1);
            end
        end
    end

    // registered table read, the ram write follows in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_we_reg   <= 1'b0;
            fill_addr_reg <= '0;
        end
        else
        begin
            fill_we_reg   <= !fill_done_reg;
            fill_addr_reg <= fill_cnt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_data_reg <= sine_rom[fill_cnt_reg];
    end

    // ---------------------------------------------------------------------------------
    // pipeline control: each stage loads when empty or when the next one loads
    // stage 0 accumulators, 1 channel phase, 2 ram data, 3 product, 4 quotient, 5 output
    // ---------------------------------------------------------------------------------
    logic [5:0] vld_reg;
    logic [5:0] ld;
    logic       accept;

    always_comb
    begin
        ld[5] = !vld_reg[5] || m_tready;
        for (int s = 4; s >= 0; s--)
        begin
            ld[s] = !vld_reg[s] || ld[s+1];
        end
    end

    assign s_tready = fill_done_reg && !fill_we_reg && ld[0];
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = vld_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                vld_reg[0] <= accept;
            end
            for (int s = 1; s < 6; s++)
            begin
                if (ld[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // stage 0: phase accumulators, stepped on accepted words with advance set
    // ---------------------------------------------------------------------------------
    logic [31:0] phase_reg [NUM_GRP];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NUM_GRP; g++)
            begin
                phase_reg[g] <= '0;
            end
        end
        else if (accept && s_tdata[0])
        begin
            for (int g = 0; g < NUM_GRP; g++)
            begin
                phase_reg[g] <= phase_reg[g] + step_reg[g];
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // stage 1: per-channel phase with its fixed offset
    // ---------------------------------------------------------------------------------
    logic [31:0] ch_phase_reg [NUM_CH];

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                ch_phase_reg[c] <= phase_reg[isg_pkg::CH_GROUP[c]] + isg_pkg::CH_OFFSET[c];
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // stage 2: quadrant fold and table read
    // ---------------------------------------------------------------------------------
    logic [AW-1:0]    rd_addr [NUM_CH];
    logic [EW-1:0]    rd_data [NUM_CH];
    logic [NUM_CH-1:0] neg_reg;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            logic [29+AW:0] pos;
            logic [AW-1:0]  j;
            pos = ch_phase_reg[c][29:0] * AW'(SINE_TABLE_DEPTH);
            j   = pos[29+AW:30];
            // odd quadrants read the quarter wave backwards
            rd_addr[c] = ch_phase_reg[c][30] ? AW'(SINE_TABLE_DEPTH) - j : j;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                // lower half cycle positive, upper half negative
                neg_reg[c] <= ch_phase_reg[c][31];
            end
        end
    end

    for (genvar r = 0; r < NUM_RAM; r++)
    begin : g_ram
        isg_ram #(
            .WIDTH (EW),
            .DEPTH (SINE_TABLE_DEPTH + 1)
        ) u_ram (
            .clk     (clk),
            .we      (fill_we_reg),
            .waddr   (fill_addr_reg),
            .wdata   (fill_data_reg),
            .re      (ld[2]),
            .raddr_a (rd_addr[2*r]),
            .raddr_b (rd_addr[2*r+1]),
            .rdata_a (rd_data[2*r]),
            .rdata_b (rd_data[2*r+1])
        );
    end

    // ---------------------------------------------------------------------------------
    // stages 3 to 5: scaling, division by the table peak, offset and saturation
    // ---------------------------------------------------------------------------------
    isg_pkg::isg_ctl_t  chan_ctl;
    logic [14:0]        ch_amp    [NUM_CH];
    logic signed [15:0] ch_offset [NUM_CH];
    logic [15:0]        ch_value  [NUM_CH];

    assign chan_ctl.ld_prod = ld[3];
    assign chan_ctl.ld_quot = ld[4];
    assign chan_ctl.ld_out  = ld[5];

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            ch_offset[c] = '0;
            case (isg_pkg::CH_GROUP[c])
                isg_pkg::GRP_ACCEL: ch_amp[c] = accel_amp_reg;
                isg_pkg::GRP_GYRO:  ch_amp[c] = gyro_amp_reg;
                isg_pkg::GRP_MAG:   ch_amp[c] = mag_amp_reg;
                default:            ch_amp[c] = isg_pkg::TEMP_SCALE;
            endcase
        end
        // gravity rides on accel z, temperature sits on its base value
        ch_offset[2]          = gravity_reg;
        ch_offset[NUM_CH - 1] = isg_pkg::TEMP_BASE;
    end

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_chan
        // sensor channels round half away from zero, temperature truncates
        isg_chan #(
            .EW    (EW),
            .ROUND (c != NUM_CH - 1)
        ) u_chan (
            .clk    (clk),
            .ctl    (chan_ctl),
            .mag    (rd_data[c]),
            .neg    (neg_reg[c]),
            .amp    (ch_amp[c]),
            .offset (ch_offset[c]),
            .value  (ch_value[c])
        );
    end

    assign m_tdata = {
        4'b0000,
        ch_value[9][11:0],
        ch_value[8], ch_value[7], ch_value[6],
        ch_value[5], ch_value[4], ch_value[3],
        ch_value[2], ch_value[1], ch_value[0]
    };

endmodule

`default_nettype wire

@@ bench/tb_imu_sine_stimulus_generator_unit.sv @@
// self-checking bench for imu_sine_stimulus_generator_unit: a queue-fed stream driver, a
// monitor with a bit-exact sample predictor, register writes between phases
// depends on isg_pkg and the imu_sine_stimulus_generator_unit rtl
`timescale 1ns / 100ps

module tb_imu_sine_stimulus_generator_unit;

    import isg_pkg::*;

    // quarter-wave table geometry, matches the block's default parameters
    localparam int                 TBL_DEPTH = 1024;
    localparam longint             SINE_PEAK = 32767;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          cfg_we    = 1'b0;
    logic [2:0]    cfg_index = '0;
    logic [31:0]   cfg_data  = '0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [7:0]    s_tdata   = '0;    // advance, zero pad
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, mag_x, mag_y, mag_z,
    // temperature (12 bits), zero pad
    logic [159:0]  m_tdata;

    // shadow of the register file
    logic [31:0]        phase_step [NUM_GRP];
    logic [14:0]        amp_accel;
    logic [14:0]        amp_gyro;
    logic [14:0]        amp_mag;
    logic signed [15:0] gravity;

    // shadow phase accumulators, indexed by sensor group
    logic [31:0]   phase_acc [NUM_GRP];
    logic [31:0]   sine_quarter [0:TBL_DEPTH];

    // words waiting to be driven and samples waiting to come out
    bit            advance_q [$];
    logic [159:0]  sample_q [$];
    int            words_queued   = 0;
    int            words_taken    = 0;
    int            mismatch_count = 0;

    // idling knobs, percent of cycles
    int            src_idle_pct  = 0;
    int            snk_stall_pct = 0;

    string fld_name [NUM_CH] = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y",
                                 "gyro_z", "mag_x", "mag_y", "mag_z", "temperature"};

    imu_sine_stimulus_generator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // q30 taylor series of sin over the first quarter, truncating after every product
    function automatic void fill_sine_quarter();
        longint unsigned ang;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned v;
        int i;
        int k;
        for (i = 0; i <= TBL_DEPTH; i++)
        begin
            ang  = (PI_HALF_Q30 * i) / TBL_DEPTH;
            term = ang;
            acc  = ang;
            for (k = 1; k <= 8; k++)
            begin
                term = (((term * ang) >> 30) * ang) >> 30;
                term = term / ((2 * k) * (2 * k + 1));
                // odd terms subtract, floored at zero
                if (k % 2 == 1)
                    acc = (acc >= term) ? acc - term : 64'd0;
                else
                    acc = acc + term;
            end
            v = (acc * SINE_PEAK + (64'd1 << 29)) >> 30;
            if (v > SINE_PEAK)
                v = SINE_PEAK;
            sine_quarter[i] = v[31:0];
        end
    endfunction

    // quadrant from the top two phase bits, index from the next ones
    function automatic longint sine_at(logic [31:0] ph);
        longint unsigned j;
        longint unsigned idx;
        longint          s;
        j   = ({34'd0, ph[29:0]} * TBL_DEPTH) >> 30;
        idx = ph[30] ? TBL_DEPTH - j : j;
        if (idx > TBL_DEPTH)
            idx = TBL_DEPTH;
        s = sine_quarter[idx];
        return ph[31] ? -s : s;
    endfunction

    // magnitude scaled with round half away from zero, sign restored
    function automatic longint scale_amp(longint s, logic [14:0] amp);
        longint m;
        longint r;
        m = (s < 0) ? -s : s;
        r = (m * amp + SINE_PEAK / 2) / SINE_PEAK;
        return (s < 0) ? -r : r;
    endfunction

    function automatic logic [15:0] sat16(longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    // steps the shadow accumulators if asked and builds the expected output word
    function automatic logic [159:0] predict_sample(bit adv);
        logic [159:0] w;
        longint       s;
        longint       tm;
        longint       t;
        int           g;
        if (adv)
        begin
            for (g = 0; g < NUM_GRP; g++)
                phase_acc[g] = phase_acc[g] + phase_step[g];
        end
        w = '0;
        w[15:0]    = sat16(scale_amp(sine_at(phase_acc[GRP_ACCEL]), amp_accel));
        w[31:16]   = sat16(scale_amp(sine_at(phase_acc[GRP_ACCEL] + 32'h2000_0000),
                                     amp_accel));
        w[47:32]   = sat16(scale_amp(sine_at(phase_acc[GRP_ACCEL] + 32'h4000_0000),
                                     amp_accel) + gravity);
        w[63:48]   = sat16(scale_amp(sine_at(phase_acc[GRP_GYRO]), amp_gyro));
        w[79:64]   = sat16(scale_amp(sine_at(phase_acc[GRP_GYRO] + 32'd715827883),
                                     amp_gyro));
        w[95:80]   = sat16(scale_amp(sine_at(phase_acc[GRP_GYRO] + 32'd1431655765),
                                     amp_gyro));
        w[111:96]  = sat16(scale_amp(sine_at(phase_acc[GRP_MAG]), amp_mag));
        w[127:112] = sat16(scale_amp(sine_at(phase_acc[GRP_MAG] + 32'd357913941),
                                     amp_mag));
        w[143:128] = sat16(scale_amp(sine_at(phase_acc[GRP_MAG] + 32'd715827883),
                                     amp_mag));
        // temperature truncates toward zero instead of rounding
        s  = sine_at(phase_acc[GRP_TEMP]);
        tm = (((s < 0) ? -s : s) * 100) / SINE_PEAK;
        t  = 2500 + ((s < 0) ? -tm : tm);
        w[155:144] = t[11:0];
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t ns: %s got %0d (0x%h), expected %0d (0x%h)", $time, what,
                 $signed(got), got, $signed(want), want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // stream driver: pops the pending queue, idles at random between words
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // a new word may go out once the current one is taken or none is shown
            if (!s_tvalid || s_tready)
            begin
                if (advance_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, advance_q.pop_front()};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on every accepted input word, checks every output word
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor_blk
        logic [159:0] want;
        int           f;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sample_q.push_back(predict_sample(s_tdata[0]));
                words_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                if (sample_q.size() == 0)
                begin
                    report_mismatch("output word with none expected", m_tdata[15:0], '0);
                end
                else
                begin
                    want = sample_q.pop_front();
                    // temperature slot also covers the zero pad above it
                    for (f = 0; f < NUM_CH; f++)
                    begin
                        if (m_tdata[16 * f +: 16] !== want[16 * f +: 16])
                            report_mismatch(fld_name[f], m_tdata[16 * f +: 16],
                                            want[16 * f +: 16]);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // sequencing helpers
    // ------------------------------------------------------------------

    task automatic write_reg(isg_reg_e idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        // only the low bits of the amplitude and gravity registers survive; the steps keep all 32 bits
        case (idx)
            REG_ACCEL_STEP: phase_step[GRP_ACCEL] = val;
            REG_GYRO_STEP:  phase_step[GRP_GYRO]  = val;
            REG_MAG_STEP:   phase_step[GRP_MAG]   = val;
            REG_TEMP_STEP:  phase_step[GRP_TEMP]  = val;
            REG_ACCEL_AMP:  amp_accel = val[14:0];
            REG_GYRO_AMP:   amp_gyro  = val[14:0];
            REG_MAG_AMP:    amp_mag   = val[14:0];
            REG_GRAVITY:    gravity   = val[15:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_regs(logic [31:0] st_a, logic [31:0] st_g, logic [31:0] st_m,
                             logic [31:0] st_t, logic [31:0] a_a, logic [31:0] a_g,
                             logic [31:0] a_m, logic [31:0] grav);
        write_reg(REG_ACCEL_STEP, st_a);
        write_reg(REG_GYRO_STEP,  st_g);
        write_reg(REG_MAG_STEP,   st_m);
        write_reg(REG_TEMP_STEP,  st_t);
        write_reg(REG_ACCEL_AMP,  a_a);
        write_reg(REG_GYRO_AMP,   a_g);
        write_reg(REG_MAG_AMP,    a_m);
        write_reg(REG_GRAVITY,    grav);
    endtask

    // phase steps: slow sweeps, full random, near wrap, coarse multiples
    function automatic logic [31:0] pick_step();
        case ($urandom_range(3))
            0:       return $urandom_range(32'h0400_0000);
            1:       return $urandom;
            2:       return 32'hFFFF_FFFF - $urandom_range(32'h000F_FFFF);
            default: return $urandom_range(64) * 32'h0100_0000;
        endcase
    endfunction

    // amplitudes and gravity get full 32-bit values so the dropped bits are exercised
    task automatic shuffle_regs();
        load_regs(pick_step(), pick_step(), pick_step(), pick_step(),
                  $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic push_word(bit adv);
        advance_q.push_back(adv);
        words_queued++;
    endtask

    // sender holds off until every expected sample is back, then the pipe settles
    task automatic wait_idle();
        while (words_taken != words_queued || sample_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    int stall_src [4] = '{0, 55, 0, 18};
    int stall_snk [4] = '{0, 0, 55, 18};

    initial
    begin : stim_blk
        int p;
        int c;
        int n;
        for (p = 0; p < NUM_GRP; p++)
        begin
            phase_step[p] = STEP_RESET[p];
            phase_acc[p]  = '0;
        end
        amp_accel = ACCEL_AMP_RESET;
        amp_gyro  = GYRO_AMP_RESET;
        amp_mag   = MAG_AMP_RESET;
        gravity   = GRAVITY_RESET;
        fill_sine_quarter();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: the sample at phase zero first, emitted twice, then ticks
        push_word(1'b0);
        push_word(1'b0);
        repeat (3) push_word(1'b1);
        wait_idle();

        // quarter-cycle steps land on every quadrant boundary, full amplitude with the
        // dropped high bits set, accel z driven past the positive limit
        load_regs(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_7FFF);
        repeat (4) push_word(1'b1);
        push_word(1'b0);
        wait_idle();

        // all-ones steps walk the phases backward through the wrap, zero amplitudes
        load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000);
        repeat (3) push_word(1'b1);
        wait_idle();

        // a three-quarter accel step with the most negative gravity saturates accel z low,
        // a zero step keeps the temperature phase frozen
        load_regs(32'hC000_0000, 32'h2AAA_AAAB, 32'hD555_5555, 32'h0000_0000,
                  32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_8000);
        repeat (4) push_word(1'b1);
        push_word(1'b0);
        wait_idle();

        // random part: four idling modes, two register settings each
        for (p = 0; p < 4; p++)
        begin
            src_idle_pct  = stall_src[p];
            snk_stall_pct = stall_snk[p];
            for (c = 0; c < 2; c++)
            begin
                shuffle_regs();
                for (n = 0; n < 75; n++)
                    push_word($urandom_range(99) < 85);
                wait_idle();
            end
        end

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog, far beyond the slowest legal run including the table fill after reset
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
